/* sv/wlbs_pkg.sv */
// ---------------------------------------------------------------------------
// wlbs_pkg: shared types and constants of the weighted load balance scheduler
// Holds field widths, status codes and the sequencer state type.
// ---------------------------------------------------------------------------
package wlbs_pkg;

  localparam int unsigned MaxProcs = 16;
  localparam int unsigned NumTypes = 4;
  localparam int unsigned CntW     = 31;
  localparam int unsigned WgtW     = 16;
  localparam int unsigned ProcW    = 4;
  localparam int unsigned LoadW    = $clog2(MaxProcs + 1);
  localparam int unsigned TypeW    = 2;
  localparam int unsigned SumW     = CntW + $clog2(MaxProcs);
  localparam int unsigned WremW    = WgtW + $clog2(MaxProcs);
  localparam int unsigned DvdW     = SumW + WgtW + 1;
  localparam int unsigned KeyW     = SumW + 2;
  localparam int unsigned MaxXfers = 60;
  localparam int unsigned XferW    = 6;
  localparam int unsigned StatW    = 2;

  localparam logic [StatW-1:0] StatOk       = 2'd0;
  localparam logic [StatW-1:0] StatZeroWt   = 2'd1;
  localparam logic [StatW-1:0] StatOverflow = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_SUM_RD,
    S_SUM_ACC,
    S_GOAL_INIT,
    S_GOAL_RD,
    S_GOAL_MUL,
    S_GOAL_DIV,
    S_GOAL_WR,
    S_CHECK,
    S_SORT_I,
    S_SORT_LD,
    S_SORT_J,
    S_SORT_CMP,
    S_SORT_WB,
    S_PR_S,
    S_PR_SL,
    S_PR_IN,
    S_PR_L,
    S_NEXT,
    S_CLOSE
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

endpackage

/* sv/wlbs_div.sv */
// ---------------------------------------------------------------------------
// wlbs_div: restoring divider
// Unsigned divide, one quotient bit per cycle, used for goal apportionment.
// ---------------------------------------------------------------------------
module wlbs_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wlbs_pkg::DvdW-1:0]      dividend_i,
  input  logic [wlbs_pkg::WremW-1:0]     divisor_i,
  output wlbs_pkg::div_ctl_t             ctl_o,
  output logic [wlbs_pkg::DvdW-1:0]      quot_o
);

  localparam int unsigned CntBits = $clog2(wlbs_pkg::DvdW + 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CntBits-1:0]            cnt_q, cnt_d;
  logic [wlbs_pkg::DvdW-1:0]     quo_q, quo_d;
  logic [wlbs_pkg::WremW:0]      rem_q, rem_d;
  logic [wlbs_pkg::WremW-1:0]    dsr_q, dsr_d;
  logic [wlbs_pkg::WremW:0]      rem_sh;
  logic [wlbs_pkg::WremW:0]      rem_sub;
  logic                          fits;

  assign rem_sh  = {rem_q[wlbs_pkg::WremW-1:0], quo_q[wlbs_pkg::DvdW-1]};
  assign fits    = rem_sh >= {1'b0, dsr_q};
  assign rem_sub = rem_sh - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub : rem_sh;
      quo_d = {quo_q[wlbs_pkg::DvdW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntBits'(wlbs_pkg::DvdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign ctl_o.start = start_i;
  assign ctl_o.busy  = busy_q;
  assign ctl_o.done  = done_q;
  assign quot_o      = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without a run");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q < CntBits'(wlbs_pkg::DvdW)) else $error("divider count overrun");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !done_d) |=> busy_q) else $error("divider dropped busy early");

endmodule

/* sv/weighted_load_balance_scheduler.sv */
// ---------------------------------------------------------------------------
// weighted_load_balance_scheduler: per-type transfer plan from processor loads
// Loads one processor per item, then apportions goals, sorts by surplus and
// pairs senders with receivers, emitting one item per transfer and a status.
// ---------------------------------------------------------------------------
// a non-final item is stored as four count writes to one port; a final
// item also runs, per type, goal apportionment through the divider, an
// exchange sort by surplus and the pairing of senders with receivers;
// output stalls can hold the transfer and closing items
// reset clears the sequencer, load count and flags; the count store is
// written before it is read and needs no clearing
module weighted_load_balance_scheduler (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // verts_count, lines_count, polys_count, strips_count, proc_weight, pad
  input  logic [143:0] s_axis_tdata_i,
  // final_proc
  input  logic         s_axis_tlast_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // from_proc, to_proc, cell_number, pad
  output logic [39:0]  m_axis_tdata_o,
  // cell_type, status
  output logic [3:0]   m_axis_tuser_o,
  // end_of_run
  output logic         m_axis_tlast_o
);

  localparam int unsigned CntW  = wlbs_pkg::CntW;
  localparam int unsigned SumW  = wlbs_pkg::SumW;
  localparam int unsigned WremW = wlbs_pkg::WremW;
  localparam int unsigned DvdW  = wlbs_pkg::DvdW;
  localparam int unsigned KeyW  = wlbs_pkg::KeyW;
  localparam int unsigned LoadW = wlbs_pkg::LoadW;
  localparam int unsigned ProcW = wlbs_pkg::ProcW;
  localparam int unsigned TypeW = wlbs_pkg::TypeW;

  wlbs_pkg::state_e state_q, state_d;

  // count store, one write and one registered read per cycle
  logic [CntW-1:0] cnt_mem [wlbs_pkg::NumTypes*wlbs_pkg::MaxProcs];
  logic [CntW-1:0] cnt_rd_q;
  logic [TypeW+ProcW-1:0] cnt_ra, cnt_wa;
  logic cnt_we;
  logic [CntW-1:0] cnt_wd;

  logic [wlbs_pkg::WgtW-1:0] wgt_q [wlbs_pkg::MaxProcs];

  // surplus store with load index
  logic signed [KeyW-1:0] key_mem [wlbs_pkg::MaxProcs];
  logic [ProcW-1:0]       idx_mem [wlbs_pkg::MaxProcs];
  logic signed [KeyW-1:0] key_rd_q;
  logic [ProcW-1:0]       idx_rd_q;
  logic [ProcW-1:0]       sr_a, sw_a;
  logic                   sw_e;
  logic signed [KeyW-1:0] sw_key;
  logic [ProcW-1:0]       sw_idx;

  logic [CntW-1:0]  in_cnt_q [wlbs_pkg::NumTypes];
  logic [wlbs_pkg::WgtW-1:0] in_wgt_q;
  logic             in_last_q;

  logic [LoadW-1:0] loaded_q, loaded_d;
  logic             ovf_q, ovf_d;
  logic [TypeW-1:0] lc_q, lc_d;
  logic [TypeW-1:0] t_q, t_d;
  logic [LoadW-1:0] p_q, p_d;
  logic [SumW-1:0]  total_q, total_d;
  logic [WremW-1:0] wrem_q, wrem_d;
  logic [SumW-1:0]  remn_q, remn_d;
  logic [SumW-1:0]  gsum_q, gsum_d;
  logic [DvdW-1:0]  prod_q, prod_d;
  logic [DvdW-1:0]  gq_q, gq_d;
  logic [wlbs_pkg::StatW-1:0] stat_q, stat_d;
  logic [wlbs_pkg::XferW-1:0] k_q, k_d;
  logic [LoadW-1:0] i_q, i_d, j_q, j_d;
  logic signed [KeyW-1:0] hkey_q, hkey_d;
  logic [ProcW-1:0] hidx_q, hidx_d;
  logic [LoadW-1:0] s_q, s_d, l_q, l_d;
  logic signed [KeyW-1:0] send_q, send_d;
  logic [ProcW-1:0] os_q, os_d;

  logic             ov_q, ov_d;
  logic [39:0]      od_q, od_d;
  logic [3:0]       ou_q, ou_d;
  logic             ol_q, ol_d;
  logic             out_free;

  logic             div_start;
  wlbs_pkg::div_ctl_t div_ctl;
  logic [DvdW-1:0]  div_quot;
  logic [SumW-1:0]  g_val;
  logic signed [KeyW-1:0] recv, amt;
  logic             in_acc;
  logic             emit;

  assign out_free = !ov_q || m_axis_tready_i;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == wlbs_pkg::S_IDLE);

  assign g_val = (gq_q > DvdW'(remn_q)) ? remn_q : gq_q[SumW-1:0];
  assign recv  = -key_rd_q;
  assign amt   = (send_q >= recv) ? recv : send_q;
  assign emit  = (amt > 0) && (k_q < wlbs_pkg::XferW'(wlbs_pkg::MaxXfers));

  wlbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q + DvdW'(wrem_q >> 1)),
    .divisor_i  (wrem_q),
    .ctl_o      (div_ctl),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d  = state_q;
    loaded_d = loaded_q;
    ovf_d    = ovf_q;
    lc_d     = lc_q;
    t_d      = t_q;
    p_d      = p_q;
    total_d  = total_q;
    wrem_d   = wrem_q;
    remn_d   = remn_q;
    gsum_d   = gsum_q;
    prod_d   = prod_q;
    gq_d     = gq_q;
    stat_d   = stat_q;
    k_d      = k_q;
    i_d      = i_q;
    j_d      = j_q;
    hkey_d   = hkey_q;
    hidx_d   = hidx_q;
    s_d      = s_q;
    l_d      = l_q;
    send_d   = send_q;
    os_d     = os_q;
    ov_d     = ov_q && !m_axis_tready_i;
    od_d     = od_q;
    ou_d     = ou_q;
    ol_d     = ol_q;
    cnt_ra   = {t_q, p_q[ProcW-1:0]};
    cnt_wa   = {lc_q, loaded_q[ProcW-1:0]};
    cnt_we   = 1'b0;
    cnt_wd   = in_cnt_q[lc_q];
    sr_a     = p_q[ProcW-1:0];
    sw_a     = p_q[ProcW-1:0];
    sw_e     = 1'b0;
    sw_key   = hkey_q;
    sw_idx   = hidx_q;
    div_start = 1'b0;

    case (state_q)
      wlbs_pkg::S_IDLE: begin
        if (in_acc) begin
          lc_d    = '0;
          state_d = wlbs_pkg::S_LOAD;
        end
      end
      wlbs_pkg::S_LOAD: begin
        if (loaded_q == LoadW'(wlbs_pkg::MaxProcs)) begin
          ovf_d   = 1'b1;
          state_d = in_last_q ? wlbs_pkg::S_CLOSE : wlbs_pkg::S_IDLE;
          stat_d  = wlbs_pkg::StatOverflow;
        end else begin
          cnt_we = 1'b1;
          lc_d   = lc_q + 1'b1;
          if (lc_q == TypeW'(wlbs_pkg::NumTypes - 1)) begin
            loaded_d = loaded_q + 1'b1;
            if (!in_last_q) begin
              state_d = wlbs_pkg::S_IDLE;
            end else if (ovf_q) begin
              stat_d  = wlbs_pkg::StatOverflow;
              state_d = wlbs_pkg::S_CLOSE;
            end else begin
              t_d     = '0;
              p_d     = '0;
              total_d = '0;
              wrem_d  = '0;
              stat_d  = wlbs_pkg::StatOk;
              k_d     = '0;
              state_d = wlbs_pkg::S_SUM_RD;
            end
          end
        end
      end
      wlbs_pkg::S_SUM_RD: begin
        state_d = wlbs_pkg::S_SUM_ACC;
      end
      wlbs_pkg::S_SUM_ACC: begin
        total_d = total_q + SumW'(cnt_rd_q);
        wrem_d  = wrem_q + WremW'(wgt_q[p_q[ProcW-1:0]]);
        p_d     = p_q + 1'b1;
        state_d = (p_q == loaded_q - 1'b1) ? wlbs_pkg::S_GOAL_INIT : wlbs_pkg::S_SUM_RD;
      end
      wlbs_pkg::S_GOAL_INIT: begin
        remn_d  = total_q;
        gsum_d  = '0;
        p_d     = '0;
        state_d = wlbs_pkg::S_GOAL_RD;
      end
      wlbs_pkg::S_GOAL_RD: begin
        prod_d  = DvdW'(remn_q * wgt_q[p_q[ProcW-1:0]]);
        state_d = wlbs_pkg::S_GOAL_MUL;
      end
      wlbs_pkg::S_GOAL_MUL: begin
        if (wrem_q == '0) begin
          gq_d    = '0;
          state_d = wlbs_pkg::S_GOAL_WR;
        end else begin
          div_start = 1'b1;
          state_d   = wlbs_pkg::S_GOAL_DIV;
        end
      end
      wlbs_pkg::S_GOAL_DIV: begin
        if (div_ctl.done) begin
          gq_d    = div_quot;
          state_d = wlbs_pkg::S_GOAL_WR;
        end
      end
      wlbs_pkg::S_GOAL_WR: begin
        sw_e   = 1'b1;
        sw_key = $signed(KeyW'(cnt_rd_q) - KeyW'(g_val));
        sw_idx = p_q[ProcW-1:0];
        remn_d = remn_q - g_val;
        gsum_d = gsum_q + g_val;
        wrem_d = wrem_q - ((WremW'(wgt_q[p_q[ProcW-1:0]]) <= wrem_q) ?
                           WremW'(wgt_q[p_q[ProcW-1:0]]) : wrem_q);
        p_d    = p_q + 1'b1;
        state_d = (p_q == loaded_q - 1'b1) ? wlbs_pkg::S_CHECK : wlbs_pkg::S_GOAL_RD;
      end
      wlbs_pkg::S_CHECK: begin
        if (gsum_q != total_q) begin
          stat_d  = wlbs_pkg::StatZeroWt;
          state_d = wlbs_pkg::S_NEXT;
        end else if (loaded_q < LoadW'(2)) begin
          state_d = wlbs_pkg::S_NEXT;
        end else begin
          i_d     = '0;
          state_d = wlbs_pkg::S_SORT_I;
        end
      end
      wlbs_pkg::S_SORT_I: begin
        sr_a    = i_q[ProcW-1:0];
        state_d = wlbs_pkg::S_SORT_LD;
      end
      wlbs_pkg::S_SORT_LD: begin
        hkey_d  = key_rd_q;
        hidx_d  = idx_rd_q;
        j_d     = i_q + 1'b1;
        state_d = wlbs_pkg::S_SORT_J;
      end
      wlbs_pkg::S_SORT_J: begin
        sr_a    = j_q[ProcW-1:0];
        state_d = wlbs_pkg::S_SORT_CMP;
      end
      wlbs_pkg::S_SORT_CMP: begin
        // held entry sits at position i; swap when it is smaller
        if (hkey_q < key_rd_q) begin
          sw_e   = 1'b1;
          sw_a   = j_q[ProcW-1:0];
          hkey_d = key_rd_q;
          hidx_d = idx_rd_q;
        end
        j_d     = j_q + 1'b1;
        state_d = (j_q == loaded_q - 1'b1) ? wlbs_pkg::S_SORT_WB : wlbs_pkg::S_SORT_J;
      end
      wlbs_pkg::S_SORT_WB: begin
        sw_e = 1'b1;
        sw_a = i_q[ProcW-1:0];
        i_d  = i_q + 1'b1;
        if (i_q + LoadW'(2) >= loaded_q) begin
          s_d     = '0;
          l_d     = loaded_q - 1'b1;
          state_d = wlbs_pkg::S_PR_S;
        end else begin
          state_d = wlbs_pkg::S_SORT_I;
        end
      end
      wlbs_pkg::S_PR_S: begin
        sr_a    = s_q[ProcW-1:0];
        state_d = (s_q < l_q) ? wlbs_pkg::S_PR_SL : wlbs_pkg::S_NEXT;
      end
      wlbs_pkg::S_PR_SL: begin
        send_d  = key_rd_q;
        os_d    = idx_rd_q;
        state_d = wlbs_pkg::S_PR_IN;
      end
      wlbs_pkg::S_PR_IN: begin
        sr_a = l_q[ProcW-1:0];
        if (send_q > 0 && s_q < l_q) begin
          state_d = wlbs_pkg::S_PR_L;
        end else begin
          s_d     = s_q + 1'b1;
          state_d = wlbs_pkg::S_PR_S;
        end
      end
      wlbs_pkg::S_PR_L: begin
        sr_a = l_q[ProcW-1:0];
        if (!emit || out_free) begin
          if (emit) begin
            ov_d = 1'b1;
            od_d = {1'b0, amt[CntW-1:0], idx_rd_q, os_q};
            ou_d = {wlbs_pkg::StatOk, t_q};
            ol_d = 1'b0;
            k_d  = k_q + 1'b1;
          end
          if (amt > 0) begin
            sw_e   = 1'b1;
            sw_a   = l_q[ProcW-1:0];
            sw_key = key_rd_q + amt;
            sw_idx = idx_rd_q;
          end
          if (send_q >= recv) begin
            send_d = send_q - ((recv > 0) ? recv : '0);
            l_d    = l_q - 1'b1;
          end else begin
            send_d = '0;
          end
          state_d = wlbs_pkg::S_PR_IN;
        end
      end
      wlbs_pkg::S_NEXT: begin
        t_d     = t_q + 1'b1;
        p_d     = '0;
        total_d = '0;
        wrem_d  = '0;
        state_d = (t_q == TypeW'(wlbs_pkg::NumTypes - 1)) ? wlbs_pkg::S_CLOSE :
                  wlbs_pkg::S_SUM_RD;
      end
      wlbs_pkg::S_CLOSE: begin
        if (out_free) begin
          ov_d     = 1'b1;
          od_d     = '0;
          ou_d     = {stat_q, 2'b00};
          ol_d     = 1'b1;
          loaded_d = '0;
          ovf_d    = 1'b0;
          stat_d   = wlbs_pkg::StatOk;
          k_d      = '0;
          state_d  = wlbs_pkg::S_IDLE;
        end
      end
      default: state_d = wlbs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wlbs_pkg::S_IDLE;
      loaded_q <= '0;
      ovf_q    <= 1'b0;
      stat_q   <= wlbs_pkg::StatOk;
      k_q      <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      ovf_q    <= ovf_d;
      stat_q   <= stat_d;
      k_q      <= k_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lc_q    <= lc_d;
    t_q     <= t_d;
    p_q     <= p_d;
    total_q <= total_d;
    wrem_q  <= wrem_d;
    remn_q  <= remn_d;
    gsum_q  <= gsum_d;
    prod_q  <= prod_d;
    gq_q    <= gq_d;
    i_q     <= i_d;
    j_q     <= j_d;
    hkey_q  <= hkey_d;
    hidx_q  <= hidx_d;
    s_q     <= s_d;
    l_q     <= l_d;
    send_q  <= send_d;
    os_q    <= os_d;
    od_q    <= od_d;
    ou_q    <= ou_d;
    ol_q    <= ol_d;
    if (in_acc) begin
      in_cnt_q[0] <= s_axis_tdata_i[30:0];
      in_cnt_q[1] <= s_axis_tdata_i[61:31];
      in_cnt_q[2] <= s_axis_tdata_i[92:62];
      in_cnt_q[3] <= s_axis_tdata_i[123:93];
      in_wgt_q    <= s_axis_tdata_i[139:124];
      in_last_q   <= s_axis_tlast_i;
    end
    if (state_q == wlbs_pkg::S_LOAD && cnt_we && lc_q == '0) begin
      wgt_q[loaded_q[ProcW-1:0]] <= in_wgt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sw_e) begin
      key_mem[sw_a] <= sw_key;
      idx_mem[sw_a] <= sw_idx;
    end
    key_rd_q <= key_mem[sr_a];
    idx_rd_q <= idx_mem[sr_a];
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = od_q;
  assign m_axis_tuser_o  = ou_q;
  assign m_axis_tlast_o  = ol_q;

  a_xfer_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= wlbs_pkg::XferW'(wlbs_pkg::MaxXfers)) else $error("transfer count over cap");
  a_load_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    loaded_q <= LoadW'(wlbs_pkg::MaxProcs)) else $error("load count over range");
  a_close_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && ol_q) |-> (od_q == '0 && ou_q[1:0] == '0)) else $error("closing item dirty");
  a_xfer_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !ol_q) |-> ou_q[3:2] == wlbs_pkg::StatOk) else $error("transfer with status");

endmodule
